### rtl/core/greedy_word_wrap_assert.svh
// ----------------------------------------------------------------------------
// greedy_word_wrap assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_ASSERT_SVH
`define GREEDY_WORD_WRAP_ASSERT_SVH

// same-cycle implication
`define GWW_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GWW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/gww_pkg.sv
// ----------------------------------------------------------------------------
// gww_pkg
// types, constants and helpers shared by the word wrap block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

    localparam int BUFFER_DEPTH = 65536;
    localparam int POS_W        = $clog2(BUFFER_DEPTH);

    localparam int CHAR_W       = 8;
    localparam int COUNT_W      = 8;
    localparam int ADDR_OUT_W   = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [0:0] REG_WRAP_COLUMN = 1'b0;

    localparam logic [CHAR_W-1:0]  CH_NL  = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_SP  = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0]  CH_ESC = 8'h1B;
    localparam logic [CHAR_W-1:0]  CH_SUB = 8'h1A;

    localparam logic [COUNT_W-1:0] WRAP_COLUMN_RESET = 8'd74;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'hFF;

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_LAST = pos_t'(BUFFER_DEPTH - 1);

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_char;
    } item_t;

    typedef struct packed {
        logic [ADDR_OUT_W-1:0] write_addr;
        logic [CHAR_W-1:0]     write_byte;
        logic                  end_of_run;
        logic                  end_of_text;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } step_t;

    typedef struct packed {
        logic room_one;
        logic room_two;
    } buf_status_t;

    function automatic pos_t pos_advance(pos_t p);
        pos_t r;
        if (p == POS_LAST) begin
            r = '0;
        end else begin
            r = p + pos_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/gww_wrap_core.sv
// ----------------------------------------------------------------------------
// gww_wrap_core
// line state and the per-byte wrap decision, one or two writes per byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gww_wrap_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [gww_pkg::COUNT_W-1:0] wrap_column,
    input  wire gww_pkg::item_t              item,
    input  wire logic                        fire,
    output gww_pkg::step_t                   step
);
    import gww_pkg::*;

    logic [COUNT_W-1:0] col_count_reg, col_count_next;
    pos_t               wr_pos_reg, wr_pos_next;
    logic               sp_pend_reg, sp_pend_next;
    pos_t               sp_pos_reg, sp_pos_next;
    logic [COUNT_W-1:0] since_sp_reg, since_sp_next;

    logic               is_sp, is_nl, counted, brk, byte_path, two;
    logic [COUNT_W-1:0] lim, cc0, css0, cc_b, css_b;
    logic               pend0;
    pos_t               spos0, wp1, wp2, nl_addr, byte_addr;
    result_t            nl_res, byte_res;

    assign is_sp   = (item.char_in == CH_SP);
    assign is_nl   = (item.char_in == CH_NL);
    assign counted = !((item.char_in == CH_BS) || (item.char_in == CH_ESC)
                       || (item.char_in == CH_SUB));

    assign cc0   = is_nl ? '0 : col_count_reg;
    assign pend0 = is_sp || (!is_nl && sp_pend_reg);
    assign spos0 = is_sp ? wr_pos_reg : sp_pos_reg;
    assign css0  = (is_sp || is_nl) ? '0 : since_sp_reg;
    assign lim   = (wrap_column == '0) ? COUNT_W'(1) : wrap_column;
    assign brk   = (cc0 >= lim);

    assign wp1 = pos_advance(wr_pos_reg);
    assign wp2 = pos_advance(wp1);

    always_comb begin
        two          = 1'b0;
        byte_path    = 1'b1;
        nl_addr      = wr_pos_reg;
        byte_addr    = wr_pos_reg;
        wr_pos_next  = wp1;
        cc_b         = cc0;
        css_b        = css0;
        sp_pend_next = pend0;
        sp_pos_next  = spos0;
        if (brk) begin
            if (is_sp) begin
                // the space itself becomes the break
                byte_path    = 1'b0;
                cc_b         = '0;
                css_b        = '0;
                sp_pend_next = 1'b0;
            end else if (pend0) begin
                two          = 1'b1;
                nl_addr      = spos0;
                cc_b         = css0;
                css_b        = '0;
                sp_pend_next = 1'b0;
            end else begin
                two          = 1'b1;
                byte_addr    = wp1;
                wr_pos_next  = wp2;
                cc_b         = '0;
            end
        end

        col_count_next = cc_b;
        if (byte_path && counted && (cc_b != COUNT_MAX)) begin
            col_count_next = cc_b + COUNT_W'(1);
        end
        since_sp_next = css_b;
        if (byte_path && counted && sp_pend_next && !is_sp && (css_b != COUNT_MAX)) begin
            since_sp_next = css_b + COUNT_W'(1);
        end
    end

    always_comb begin
        nl_res.write_addr    = ADDR_OUT_W'(nl_addr);
        nl_res.write_byte    = CH_NL;
        nl_res.end_of_run    = !byte_path;
        nl_res.end_of_text   = !byte_path && item.last_char;
        byte_res.write_addr  = ADDR_OUT_W'(byte_addr);
        byte_res.write_byte  = item.char_in;
        byte_res.end_of_run  = 1'b1;
        byte_res.end_of_text = item.last_char;
        step.two             = two;
        if (!byte_path || two) begin
            step.first = nl_res;
        end else begin
            step.first = byte_res;
        end
        step.second = byte_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last_char)) begin
            col_count_reg <= '0;
            wr_pos_reg    <= '0;
            sp_pend_reg   <= 1'b0;
            sp_pos_reg    <= '0;
            since_sp_reg  <= '0;
        end else if (fire) begin
            col_count_reg <= col_count_next;
            wr_pos_reg    <= wr_pos_next;
            sp_pend_reg   <= sp_pend_next;
            sp_pos_reg    <= sp_pos_next;
            since_sp_reg  <= since_sp_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/gww_out_buf.sv
// ----------------------------------------------------------------------------
// gww_out_buf
// two-slot result buffer feeding the master stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gww_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire gww_pkg::step_t   step,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output gww_pkg::result_t      head,
    output gww_pkg::buf_status_t  status
);
    import gww_pkg::*;

    result_t     slot0_reg, slot0_next;
    result_t     slot1_reg, slot1_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign out_valid       = (cnt_reg != 2'd0);
    assign head            = slot0_reg;
    assign pop             = out_valid && out_ready;
    assign status.room_one = (cnt_reg != 2'd2);
    assign status.room_two = (cnt_reg == 2'd0);

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (push) begin
            if (cnt_next == 2'd0) begin
                slot0_next = step.first;
                if (step.two) begin
                    slot1_next = step.second;
                    cnt_next   = 2'd2;
                end else begin
                    cnt_next   = 2'd1;
                end
            end else begin
                slot1_next = step.first;
                cnt_next   = 2'd2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

### rtl/core/greedy_word_wrap.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap
// wraps a byte stream at a set column, emitting buffer address/byte writes
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_       in         text byte (tdata), final byte of text (tlast)
//  m_       out        address and byte (tdata), last write of byte (tuser),
//                      last write of text (tlast)
//  apb      in/out     wrap_column at byte address 0
//
//  one byte per cycle while the m_ side keeps up; a byte other than a space
//  that forces a break writes twice and waits until the two-slot output buffer
//  is empty, and the byte after it waits for a free slot; a breaking space
//  writes only the newline; results pass the input register and output buffer
//  synchronous active-low reset clears line state, wrap_column returns to 74
//  s_tready depends only on registers, so a stalled m_ side never ripples
//  combinationally back to the s_ side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrap (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // char_in[7:0]
    input  wire logic [gww_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // write_addr[15:0], write_byte[23:16]
    output logic [gww_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // end_of_run[0]
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gww_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gww_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gww_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import gww_pkg::*;

    logic [COUNT_W-1:0] wrap_col_reg;
    item_t              in_reg;
    logic               in_valid_reg, in_valid_next;
    logic               s_xfer, fire, cfg_wr;
    logic [0:0]         reg_index;
    step_t              step;
    buf_status_t        buf_status;
    result_t            head;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_wr    = psel && penable && pwrite && pready && (reg_index == REG_WRAP_COLUMN);
    assign prdata    = (reg_index == REG_WRAP_COLUMN) ? APB_DATA_W'(wrap_col_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_col_reg <= WRAP_COLUMN_RESET;
        end else if (cfg_wr) begin
            wrap_col_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign fire     = in_valid_reg && (step.two ? buf_status.room_two : buf_status.room_one);
    assign s_tready = !in_valid_reg || fire;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg.char_in   <= s_tdata[CHAR_W-1:0];
            in_reg.last_char <= s_tlast;
        end
    end

    gww_wrap_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wrap_column (wrap_col_reg),
        .item        (in_reg),
        .fire        (fire),
        .step        (step)
    );

    gww_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .step      (step),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .head      (head),
        .status    (buf_status)
    );

    assign m_tdata    = {head.write_byte, head.write_addr};
    assign m_tuser[0] = head.end_of_run;
    assign m_tlast    = head.end_of_text;

endmodule

`default_nettype wire

### rtl/core/gww_checker.sv
// ----------------------------------------------------------------------------
// gww_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "greedy_word_wrap_assert.svh"

module gww_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [gww_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [0:0]                      m_tuser,
    input  wire logic                            m_tlast,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready
);
    import gww_pkg::*;

    // stalled transfer holds
    `GWW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // end of text only on the last write of a byte
    `GWW_ASSERT_IMPLY(a_eot_is_eor, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0], "end of text without end of run")

    // first of a pair is always a line break
    `GWW_ASSERT_IMPLY(a_pair_first_nl, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[OUT_TDATA_W-1:ADDR_OUT_W] == CH_NL, "first write of a pair is not a newline")

    // second of a pair follows straight away
    `GWW_ASSERT_NEXT(a_pair_follows, aclk, aresetn, m_tvalid && m_tready && !m_tuser[0], m_tvalid, "second write of a pair missing")

endmodule

bind greedy_word_wrap gww_checker u_gww_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
